FILE: src/lbc_pkg.sv
// lbc_pkg: shared types and constants of the LRU block buffer cache.
// No dependencies.
`timescale 1ns / 1ps
package lbc_pkg;

	localparam int NUM_BUFFERS_DEF = 32;
	localparam int DEV_W = 8;
	localparam int BLK_W = 32;
	localparam int TAG_W = DEV_W + BLK_W;

	localparam logic [1:0] MODE_READ    = 2'd0;
	localparam logic [1:0] MODE_WRITE   = 2'd1;
	localparam logic [1:0] MODE_RELEASE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BUSY    = 2'd1;
	localparam logic [1:0] ST_NOFREE  = 2'd2;
	localparam logic [1:0] ST_NOTHELD = 2'd3;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_ALLOC,
		S_REL_RD,
		S_REL_GET,
		S_SWEEP,
		S_REL_FIX,
		S_RESP
	} state_t;

endpackage

FILE: src/lbc_if.sv
// lbc_req_if / lbc_rsp_if: valid/ready channels of the buffer cache.
// Depends on nothing.
`timescale 1ns / 1ps
interface lbc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  device;
	logic [31:0] block_number;
	logic [4:0]  buffer_index;
	modport source(output valid, mode, device, block_number, buffer_index, input ready);
	modport sink(input valid, mode, device, block_number, buffer_index, output ready);
endinterface

interface lbc_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [4:0] entry_index;
	logic       cache_hit;
	logic       fetch_needed;
	logic       write_out;
	modport source(output valid, status, entry_index, cache_hit, fetch_needed, write_out,
		input ready);
	modport sink(input valid, status, entry_index, cache_hit, fetch_needed, write_out,
		output ready);
endinterface

FILE: src/lru_block_buffer_cache_top.sv
// Tag and recency engine of the block buffer cache, with tag/rank RAM.
// Depends on lbc_pkg and lbc_if.
//
// A read request scans the tag RAM entry by entry, one read per cycle; on
// a miss the least recent free entry is recycled. A release reads the
// entry's rank, then sweeps the whole RAM through its single read and write
// port to age newer entries. After reset the RAM ranks are loaded by a pass
// during which no item is accepted.
// Entry indexes on the ports are 5 bits wide.
`timescale 1ns / 1ps
module lru_block_buffer_cache_top
	import lbc_pkg::*;
#(
	parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
	input logic clk,
	input logic arst_n,
	lbc_req_if.sink req,
	lbc_rsp_if.source rsp
);

	localparam int IW = $clog2(NUM_BUFFERS);
	localparam int WW = TAG_W + IW;
	localparam logic [IW:0] LAST = (IW + 1)'(NUM_BUFFERS - 1);
	localparam logic [IW-1:0] TOP_RANK = IW'(NUM_BUFFERS - 1);

	state_t state_q, state_d;

	logic [WW-1:0] mem [NUM_BUFFERS];
	logic [WW-1:0] rdata_s1;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	logic          mem_re, mem_we;
	logic [IW-1:0] mem_raddr, mem_waddr;
	logic [WW-1:0] mem_wdata;

	logic [IW:0]   cnt_q;
	logic [NUM_BUFFERS-1:0] present_q, busy_q, dvalid_q;

	logic [TAG_W-1:0] tag_q;
	logic [IW-1:0] bi_q;
	logic          found_q;
	logic [IW-1:0] vict_q, vict_rank_q, rel_rank_q;
	logic [TAG_W-1:0] rel_tag_q;

	logic [1:0] res_status_q;
	logic [4:0] res_idx_q;
	logic       res_hit_q, res_fetch_q, res_wr_q;

	logic       rsp_valid_q;

	logic          acc, held, match_s1, last_s1, resp_load;
	logic [IW-1:0] bi_idx, rank_s1;

	assign bi_idx   = IW'(req.buffer_index);
	assign held     = (32'(req.buffer_index) < NUM_BUFFERS) && busy_q[bi_idx];
	assign acc      = (state_q == S_IDLE) && req.valid;
	assign rank_s1  = rdata_s1[IW-1:0];
	assign match_s1 = vld_s1 && present_q[idx_s1] && (rdata_s1[WW-1:IW] == tag_q);
	assign last_s1  = ({1'b0, idx_s1} == LAST);
	assign resp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT:    if (cnt_q == LAST) state_d = S_IDLE;
			S_IDLE: begin
				if (req.valid) begin
					if (req.mode == MODE_READ) state_d = S_SCAN;
					else if (req.mode == MODE_RELEASE && held) state_d = S_REL_RD;
					else state_d = S_RESP;
				end
			end
			S_SCAN: begin
				if (match_s1) state_d = S_RESP;
				else if (vld_s1 && last_s1) state_d = S_ALLOC;
			end
			S_ALLOC:   state_d = S_RESP;
			S_REL_RD:  state_d = S_REL_GET;
			S_REL_GET: state_d = S_SWEEP;
			S_SWEEP:   if (vld_s1 && last_s1) state_d = S_REL_FIX;
			S_REL_FIX: state_d = S_RESP;
			S_RESP:    if (resp_load) state_d = S_IDLE;
			default:   state_d = S_INIT;
		endcase
	end

	always_comb begin
		req.ready = (state_q == S_IDLE);
		mem_re    = 1'b0;
		mem_raddr = cnt_q[IW-1:0];
		mem_we    = 1'b0;
		mem_waddr = cnt_q[IW-1:0];
		mem_wdata = {{TAG_W{1'b0}}, cnt_q[IW-1:0]};
		unique case (state_q)
			S_INIT:   mem_we = 1'b1;
			S_SCAN:   mem_re = (cnt_q <= LAST);
			S_ALLOC: begin
				mem_we    = found_q;
				mem_waddr = vict_q;
				mem_wdata = {tag_q, vict_rank_q};
			end
			S_REL_RD: begin
				mem_re    = 1'b1;
				mem_raddr = bi_q;
			end
			S_SWEEP: begin
				mem_re    = (cnt_q <= LAST);
				mem_we    = vld_s1 && (rank_s1 > rel_rank_q);
				mem_waddr = idx_s1;
				mem_wdata = {rdata_s1[WW-1:IW], rank_s1 - 1'b1};
			end
			S_REL_FIX: begin
				mem_we    = 1'b1;
				mem_waddr = bi_q;
				mem_wdata = {rel_tag_q, TOP_RANK};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_s1 <= mem[mem_raddr];
		idx_s1 <= mem_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			present_q   <= '0;
			busy_q      <= '0;
			dvalid_q    <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= mem_re && (state_q == S_SCAN || state_q == S_SWEEP);
			if (state_q == S_INIT || ((state_q == S_SCAN || state_q == S_SWEEP) && mem_re))
				cnt_q <= cnt_q + 1'b1;
			else if (state_q != S_SCAN && state_q != S_SWEEP)
				cnt_q <= '0;
			if (acc) found_q <= 1'b0;
			if (state_q == S_SCAN && vld_s1 && !match_s1 && !busy_q[idx_s1]
				&& (!found_q || rank_s1 < vict_rank_q))
				found_q <= 1'b1;
			if (state_q == S_SCAN && match_s1 && !busy_q[idx_s1]) begin
				busy_q[idx_s1]   <= 1'b1;
				dvalid_q[idx_s1] <= 1'b1;
			end
			if (state_q == S_ALLOC && found_q) begin
				present_q[vict_q] <= 1'b1;
				busy_q[vict_q]    <= 1'b1;
				dvalid_q[vict_q]  <= 1'b1;
			end
			if (state_q == S_REL_FIX) busy_q[bi_q] <= 1'b0;
			if (resp_load) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			tag_q        <= {req.device, req.block_number};
			bi_q         <= bi_idx;
			res_status_q <= ST_NOTHELD;
			res_idx_q    <= (req.mode == MODE_WRITE || req.mode == MODE_RELEASE)
				? req.buffer_index : 5'd0;
			res_hit_q    <= 1'b0;
			res_fetch_q  <= 1'b0;
			res_wr_q     <= 1'b0;
			if (req.mode == MODE_WRITE && held) begin
				res_status_q <= ST_OK;
				res_wr_q     <= 1'b1;
			end
			if (req.mode == MODE_RELEASE && held) res_status_q <= ST_OK;
		end
		if (state_q == S_SCAN && vld_s1 && !match_s1 && !busy_q[idx_s1]
			&& (!found_q || rank_s1 < vict_rank_q)) begin
			vict_q      <= idx_s1;
			vict_rank_q <= rank_s1;
		end
		if (state_q == S_SCAN && match_s1) begin
			res_status_q <= busy_q[idx_s1] ? ST_BUSY : ST_OK;
			res_idx_q    <= 5'(idx_s1);
			res_hit_q    <= 1'b1;
			res_fetch_q  <= !busy_q[idx_s1] && !dvalid_q[idx_s1];
		end
		if (state_q == S_ALLOC) begin
			res_status_q <= found_q ? ST_OK : ST_NOFREE;
			res_idx_q    <= found_q ? 5'(vict_q) : 5'd0;
			res_fetch_q  <= found_q;
		end
		if (state_q == S_REL_GET) begin
			rel_rank_q <= rank_s1;
			rel_tag_q  <= rdata_s1[WW-1:IW];
		end
		if (resp_load) begin
			rsp.status       <= res_status_q;
			rsp.entry_index  <= res_idx_q;
			rsp.cache_hit    <= res_hit_q;
			rsp.fetch_needed <= res_fetch_q;
			rsp.write_out    <= res_wr_q;
		end
	end

	assign rsp.valid = rsp_valid_q;

endmodule

FILE: src/lbc_checker.sv
// lbc_checker: port-level assertions on the buffer cache, bound to the top.
// Depends on lbc_pkg and lru_block_buffer_cache_top.
`timescale 1ns / 1ps
module lbc_checker
	import lbc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] status,
	input logic [4:0] entry_index,
	input logic       cache_hit,
	input logic       fetch_needed,
	input logic       write_out
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entry_index))
		else $error("stalled result changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_BUSY |-> cache_hit && !fetch_needed && !write_out)
		else $error("busy result malformed");

	a_nofree: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_NOFREE |-> entry_index == 5'd0 && !cache_hit
			&& !fetch_needed && !write_out)
		else $error("no-free result malformed");

	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && write_out |-> status == ST_OK && !cache_hit && !fetch_needed)
		else $error("write result malformed");

endmodule

bind lru_block_buffer_cache_top lbc_checker u_lbc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status(rsp.status),
	.entry_index(rsp.entry_index),
	.cache_hit(rsp.cache_hit),
	.fetch_needed(rsp.fetch_needed),
	.write_out(rsp.write_out)
);
